@@ hw/rtl/hash_table_linear_probe_unit_assert.svh @@
// Assertion macros for the linear-probe hash table checker.
// Needs clk and rst_n in the scope of each use.
`ifndef HASH_TABLE_LINEAR_PROBE_UNIT_ASSERT_SVH
`define HASH_TABLE_LINEAR_PROBE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HTLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define HTLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/htlp_pkg.sv @@
// Shared types and constants for the linear-probe hash table.
// No dependencies; every other file but the assertion macro header imports this package.
package htlp_pkg;

  // Table geometry
  localparam int TABLE_SIZE = 16;
  localparam int SLOT_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int REM_W      = SLOT_W + 1;
  localparam bit HOME_POW2  = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

  // Item fields
  localparam int KEY_W      = 16;
  localparam int WORD_W     = KEY_W + 1;
  localparam int STATUS_W   = 2;
  localparam int OUT_SLOT_W = 4;

  // Serial remainder: one hex digit of the key per cycle
  localparam int DIGIT_W = 4;
  localparam int DIG_N   = KEY_W / DIGIT_W;
  localparam int DIG_W   = (DIG_N > 1) ? $clog2(DIG_N) : 1;

  localparam logic [REM_W-1:0]  SIZE_R    = REM_W'(TABLE_SIZE);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [DIG_W-1:0]  DIG_LAST  = DIG_W'(DIG_N - 1);

  // Operation and result codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_HOME  = 4'b0100,
    S_PROBE = 4'b1000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic rem_step;
    logic advance;
    logic finish;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic rem_last;
    logic probe_end;
  } dp_stat_t;

endpackage

@@ hw/rtl/htlp_if.sv @@
// Valid/ready channel interfaces for the hash table's item and result streams.
// Depends on htlp_pkg for field widths.
interface htlp_in_if import htlp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface htlp_out_if import htlp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [OUT_SLOT_W-1:0] slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink (input valid, input status, input slot_index, output ready);
endinterface

@@ hw/rtl/hash_table_linear_probe_unit.sv @@
// Top level of the linear-probe hash table: controller plus datapath.
// Depends on htlp_pkg, htlp_if, htlp_ctrl and htlp_dp.
//
//   channel  | direction | payload                 | handshake
//   in_ch    | sink      | mode[0], key[15:0]      | valid / ready
//   out_ch   | source    | status[1:0], slot[3:0]  | valid / ready
//
// After reset the slot memory is swept clear slot by slot; in_ch.ready is low then.
// An item is accepted, then probes slot by slot from its home slot (1 to TABLE_SIZE probes),
// one probe per cycle. Tables whose size is not a power of two first work out the home
// slot as a serial remainder of the key, one hex digit at a time.
// One item is worked at a time; a new item may be taken while the last result waits.
// A finished result stalls its item until the output register is free.
module hash_table_linear_probe_unit import htlp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  htlp_in_if.sink    in_ch,
  htlp_out_if.source out_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  htlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  htlp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (in_ch.mode),
    .in_key     (in_ch.key),
    .res_status (out_ch.status),
    .res_slot   (out_ch.slot_index)
  );

endmodule

@@ hw/rtl/htlp_dp.sv @@
// Datapath: slot memory, serial home-slot remainder, probe pointer and result register.
// Depends on htlp_pkg; driven by commands from htlp_ctrl.
module htlp_dp import htlp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic                  in_mode,
  input  logic [KEY_W-1:0]      in_key,
  output logic [STATUS_W-1:0]   res_status,
  output logic [OUT_SLOT_W-1:0] res_slot
);

  // Slot memory: {valid, key} per slot
  logic [WORD_W-1:0]     mem [TABLE_SIZE];
  logic [WORD_W-1:0]     rd_data_r;
  logic [SLOT_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_addr;
  logic [WORD_W-1:0]     wr_data;

  logic [SLOT_W-1:0]     clr_addr_r;
  logic [KEY_W-1:0]      key_r;
  logic                  mode_r;
  logic [KEY_W-1:0]      keysh_r;
  logic [SLOT_W-1:0]     rem_r;
  logic [SLOT_W-1:0]     rem_nxt;
  logic [DIG_W-1:0]      dig_r;
  logic [SLOT_W-1:0]     pos_r;
  logic [SLOT_W-1:0]     home_r;
  logic [SLOT_W-1:0]     cnt_r;
  logic [SLOT_W-1:0]     pos_inc;
  logic [SLOT_W-1:0]     home_pow;
  logic [STATUS_W-1:0]   res_status_r;
  logic [OUT_SLOT_W-1:0] res_slot_r;

  logic                  slot_valid;
  logic                  slot_match;
  logic                  probe_last;
  logic                  probe_end;
  logic [STATUS_W-1:0]   res_code;
  logic [SLOT_W-1:0]     res_pos;

  // Home slot for a power-of-two table is the low key bits
  assign home_pow = in_key[SLOT_W-1:0];
  assign pos_inc  = (pos_r == SLOT_LAST) ? '0 : pos_r + 1'b1;

  // Remainder step: fold one key digit into the running remainder
  always_comb begin
    logic [REM_W-1:0]   t;
    logic [DIGIT_W-1:0] digit;
    logic [SLOT_W-1:0]  r;
    digit = keysh_r[KEY_W-1 -: DIGIT_W];
    r     = rem_r;
    for (int i = 0; i < DIGIT_W; i++) begin
      t = {r, digit[DIGIT_W-1-i]};
      if (t >= SIZE_R) begin
        t = t - SIZE_R;
      end
      r = t[SLOT_W-1:0];
    end
    rem_nxt = r;
  end

  // Probe decision on the slot just read
  assign slot_valid = rd_data_r[WORD_W-1];
  assign slot_match = (rd_data_r[KEY_W-1:0] == key_r);
  assign probe_last = (cnt_r == SLOT_LAST);

  always_comb begin
    if (mode_r == MODE_INSERT) begin
      probe_end = !slot_valid || probe_last;
      res_code  = slot_valid ? ST_FULL : ST_OK;
      res_pos   = slot_valid ? home_r : pos_r;
    end else begin
      probe_end = !slot_valid || slot_match || probe_last;
      res_code  = (slot_valid && slot_match) ? ST_OK : ST_MISS;
      res_pos   = (!slot_valid || slot_match) ? pos_r : home_r;
    end
  end

  assign stat.probe_end  = probe_end;
  assign stat.clear_last = (clr_addr_r == SLOT_LAST);
  assign stat.rem_last   = (dig_r == DIG_LAST);

  // Read address follows the next probe position
  always_comb begin
    if (cmd.accept) begin
      rd_addr = home_pow;
    end else if (cmd.rem_step) begin
      rd_addr = rem_nxt;
    end else if (cmd.advance) begin
      rd_addr = pos_inc;
    end else begin
      rd_addr = pos_r;
    end
  end

  // Write: clearing sweep, or store the key on a successful insert
  assign wr_en   = cmd.clear || (cmd.finish && (mode_r == MODE_INSERT) && !slot_valid);
  assign wr_addr = cmd.clear ? clr_addr_r : pos_r;
  assign wr_data = cmd.clear ? '0 : {1'b1, key_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Clearing sweep pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear) begin
      clr_addr_r <= stat.clear_last ? '0 : clr_addr_r + 1'b1;
    end
  end

  // Item registers, remainder and probe pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r   <= in_key;
      mode_r  <= in_mode;
      keysh_r <= in_key;
      rem_r   <= '0;
      dig_r   <= '0;
      pos_r   <= home_pow;
      home_r  <= home_pow;
      cnt_r   <= '0;
    end else if (cmd.rem_step) begin
      keysh_r <= keysh_r << DIGIT_W;
      rem_r   <= rem_nxt;
      dig_r   <= dig_r + 1'b1;
      if (stat.rem_last) begin
        pos_r  <= rem_nxt;
        home_r <= rem_nxt;
        cnt_r  <= '0;
      end
    end else if (cmd.advance) begin
      pos_r <= pos_inc;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status_r <= res_code;
      res_slot_r   <= OUT_SLOT_W'(res_pos);
    end
  end

  assign res_status = res_status_r;
  assign res_slot   = res_slot_r;

endmodule

@@ hw/rtl/htlp_ctrl.sv @@
// Controller: clearing sweep, item accept, remainder and probe sequencing, output valid.
// Depends on htlp_pkg; commands htlp_dp.
module htlp_ctrl import htlp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = HOME_POW2 ? S_PROBE : S_HOME;
        end
      end
      S_HOME: begin
        cmd.rem_step = 1'b1;
        if (stat.rem_last) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!stat.probe_end) begin
          cmd.advance = 1'b1;
        end else if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Output valid: set on finish, drop when taken
  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/htlp_chk.sv @@
// Port-level checker for the linear-probe hash table, bound to the top level.
// Depends on htlp_pkg and hash_table_linear_probe_unit_assert.svh.
`include "hash_table_linear_probe_unit_assert.svh"

module htlp_chk import htlp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [STATUS_W-1:0]   out_status,
  input logic [OUT_SLOT_W-1:0] out_slot
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `HTLP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_slot), "stalled result changed")
  `HTLP_ASSERT_NXT(a_one_item, in_acc, !in_ready, "item accepted while another is at work")
  `HTLP_ASSERT_IMP(a_pend_max, in_acc, pend_r <= 2'd1, "too many items in flight")
  `HTLP_ASSERT_IMP(a_no_extra, out_acc, pend_r != 2'd0, "result delivered with no item pending")

endmodule

bind hash_table_linear_probe_unit htlp_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_slot   (out_ch.slot_index)
);
